### hw/rtl/urpd_pkg.sv
// Shared types and constants for the ultrasonic ranger with park detection.
// Used by the result channel interface, the remainder unit and the top level.
package urpd_pkg;

    localparam int TICK_W = 14;
    localparam int CM_W   = 12;

    // Lag between the two distances that give the speed, and the ring depth.
    localparam int LAG        = 10;
    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LAG_MOD    = LAG % RING_DEPTH;

    // Register reset values.
    localparam logic [TICK_W-1:0] PERIOD_RST = 14'd10000;
    localparam logic [CM_W-1:0]   NEAR_RST   = 12'd10;
    localparam logic [CM_W-1:0]   FAR_RST    = 12'd50;
    localparam logic [CM_W-1:0]   SPEED_RST  = 12'd1;

    // Smallest period that behaves as written; lower settings act as this.
    localparam logic [TICK_W-1:0] PERIOD_MIN = 14'd3;

    // Distance is interval * 17 / 100; the divide by 100 is a multiply by
    // ceil(2^26 / 100) and a shift, exact for every 19-bit product.
    localparam int                RECIP_SHIFT = 26;
    localparam logic [19:0]       RECIP_MUL   = 20'd671089;
    localparam int                SCALED_W    = TICK_W + 5;
    localparam int                PROD_W      = SCALED_W + 20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = TICK_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_NEAR   = 2'd1,
        CFG_FAR    = 2'd2,
        CFG_SPEED  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MOD_IDLE,
        MOD_RUN,
        MOD_HOLD
    } t_mod_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mod_stat;

endpackage

### hw/rtl/urpd_in_if.sv
// Input channel of the ranger: one transfer per 10 us tick.
// Depends on nothing beyond valid/ready handshake conventions.
interface urpd_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

### hw/rtl/urpd_out_if.sv
// Result channel of the ranger: one transfer per accepted tick.
// Field widths come from urpd_pkg.
interface urpd_out_if;
    logic                      valid;
    logic                      ready;
    logic                      trigger_level;
    logic                      measure_done;
    logic [urpd_pkg::CM_W-1:0] distance_cm;
    logic [urpd_pkg::CM_W-1:0] speed_cm;
    logic                      parked;
    logic                      unparked;

    modport source (output valid, output trigger_level, output measure_done,
                    output distance_cm, output speed_cm, output parked,
                    output unparked, input ready);
    modport sink   (input valid, input trigger_level, input measure_done,
                    input distance_cm, input speed_cm, input parked,
                    input unparked, output ready);
endinterface

### hw/rtl/urpd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module urpd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/urpd_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo a 14-bit divisor.
// Depends on urpd_pkg for the state type and status struct.
module urpd_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [31:0]                 i_dividend,
    input  logic [urpd_pkg::TICK_W-1:0] i_divisor,
    input  logic                        i_take,
    output urpd_pkg::t_mod_stat         o_stat,
    output logic [urpd_pkg::TICK_W-1:0] o_rem
);
    urpd_pkg::t_mod_state r_state, n_state;
    logic [4:0]                  r_cnt;
    logic [31:0]                 r_dvd;
    logic [urpd_pkg::TICK_W-1:0] r_rem;
    logic [urpd_pkg::TICK_W-1:0] r_div;
    logic [urpd_pkg::TICK_W:0]   c_trial;
    logic                        c_ge;
    logic [urpd_pkg::TICK_W-1:0] n_rem;

    // One restoring step: the partial remainder stays below the divisor.
    always_comb begin
        c_trial = {r_rem, r_dvd[31]};
        c_ge    = (c_trial >= {1'b0, r_div});
        n_rem   = c_ge ? urpd_pkg::TICK_W'(c_trial - {1'b0, r_div})
                       : c_trial[urpd_pkg::TICK_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            urpd_pkg::MOD_IDLE: if (i_start) n_state = urpd_pkg::MOD_RUN;
            urpd_pkg::MOD_RUN:  if (r_cnt == 5'd0) n_state = urpd_pkg::MOD_HOLD;
            urpd_pkg::MOD_HOLD: if (i_take) n_state = urpd_pkg::MOD_IDLE;
            default:            n_state = urpd_pkg::MOD_IDLE;
        endcase
    end

    always_comb begin
        o_stat.busy = (r_state != urpd_pkg::MOD_IDLE);
        o_stat.done = (r_state == urpd_pkg::MOD_HOLD);
        o_rem       = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= urpd_pkg::MOD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == urpd_pkg::MOD_IDLE && i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= 5'd31;
        end else if (r_state == urpd_pkg::MOD_RUN) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 5'd1;
        end
    end
endmodule

### hw/rtl/ultrasonic_ranger_park_detect.sv
// Ultrasonic ranger with park detection: top level.
// Depends on urpd_pkg, urpd_in_if, urpd_out_if, urpd_ram and urpd_mod.
//
// The block takes one tick transfer per clock unless the result side or the
// remainder unit stalls it, and returns one result per tick through the stage
// B, stage C and output registers. The trigger counter and echo edge logic act
// in the accept cycle, the distance multiply follows, and the last stage reads
// and writes the 16-entry distance ring, a one-port-read RAM whose read for a
// measurement is issued as it enters stage C, with forwarding when the previous
// measurement writes the same entry. Ring entries carry valid flags that reset
// clears, so there is no clearing pass. While the tick count and the echo start
// both stay below the period, no tick waits on the remainder unit. After the
// period is lowered below a count already latched, a falling echo edge can need
// a full remainder, computed bit by bit; no tick is accepted during that time.
module ultrasonic_ranger_park_detect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    urpd_in_if.sink                         i_tick,
    urpd_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [urpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int TW = urpd_pkg::TICK_W;
    localparam int CW = urpd_pkg::CM_W;
    localparam int AW = urpd_pkg::RING_AW;

    // Configuration.
    logic [TW-1:0] r_period;
    logic [CW-1:0] r_near;
    logic [CW-1:0] r_far;
    logic [CW-1:0] r_speed_lim;

    // Tick state.
    logic [TW-1:0] r_tick;
    logic          r_trig;
    logic          r_echo_last;
    logic [TW-1:0] r_start;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_last_dist;
    logic [CW-1:0] r_last_speed;
    logic [urpd_pkg::RING_DEPTH-1:0] r_ring_vld;

    // Pipeline stages.
    logic          r_b_valid, r_b_done, r_b_trig;
    logic [TW-1:0] r_b_int;
    logic          r_c_valid, r_c_done, r_c_trig;
    logic [CW-1:0] r_c_dist;
    logic [AW-1:0] r_c_ptr;
    logic          r_c_fwd, r_c_old_vld;
    logic [CW-1:0] r_c_fwd_dist;
    logic          r_m_trig;
    logic          r_o_valid, r_o_trig, r_o_done, r_o_parked, r_o_unparked;
    logic [CW-1:0] r_o_dist, r_o_speed;

    // Accept-cycle logic.
    logic          in_fire, rdy_b, rdy_c, rdy_o, mv_bc, mv_co;
    logic [TW-1:0] c_p_eff, c_cnt1, n_tick;
    logic          n_trig, c_rise, c_fall;
    logic [TW-1:0] c_a, c_s, c_fast_int;
    logic [TW:0]   c_two_p;
    logic          c_fast;
    logic [31:0]   c_slow_val;
    logic          mod_start, mod_take;
    urpd_pkg::t_mod_stat     mod_stat;
    logic [TW-1:0] mod_rem;

    // Distance and ring logic.
    logic [urpd_pkg::SCALED_W-1:0] c_scaled;
    logic [urpd_pkg::PROD_W-1:0]   c_prod;
    logic [CW-1:0] c_dist_b;
    logic [AW-1:0] c_back, c_ptr_next;
    logic          c_fwd;
    logic [CW-1:0] ram_rdata, c_old, c_diff, c_new_dist, c_new_speed;
    logic          ram_we, ram_re;

    assign rdy_o   = !r_o_valid || o_res.ready;
    assign rdy_c   = !r_c_valid || rdy_o;
    assign rdy_b   = !r_b_valid || rdy_c;
    assign mv_bc   = r_b_valid && rdy_c;
    assign mv_co   = r_c_valid && rdy_o;
    assign i_tick.ready = rdy_b && !mod_stat.busy;
    assign in_fire = i_tick.valid && i_tick.ready;

    // Counter, trigger and echo edges for the tick being accepted.
    always_comb begin
        c_p_eff = (r_period < urpd_pkg::PERIOD_MIN) ? urpd_pkg::PERIOD_MIN : r_period;
        c_cnt1  = r_tick + TW'(1);
        n_tick  = c_cnt1;
        n_trig  = r_trig;
        if (c_cnt1 == TW'(1)) begin
            n_trig = 1'b1;
        end else if (c_cnt1 == TW'(2)) begin
            n_trig = 1'b0;
        end else if (c_cnt1 >= r_period) begin
            n_tick = '0;
        end
        c_rise = i_tick.echo_level && !r_echo_last;
        c_fall = !i_tick.echo_level && r_echo_last;
    end

    // Interval modulo the period. The usual cases settle with one compare and
    // subtract; the rest, such as a wrap past one period, go to the remainder unit.
    always_comb begin
        c_a        = n_tick - r_start;
        c_s        = r_start - n_tick;
        c_two_p    = {c_p_eff, 1'b0};
        c_fast     = 1'b1;
        c_fast_int = '0;
        c_slow_val = '0;
        if (n_tick >= r_start) begin
            c_slow_val = 32'(c_a);
            if (c_a < c_p_eff) begin
                c_fast_int = c_a;
            end else if ({1'b0, c_a} < c_two_p) begin
                c_fast_int = c_a - c_p_eff;
            end else begin
                c_fast = 1'b0;
            end
        end else if (c_s <= c_p_eff) begin
            c_fast_int = c_p_eff - c_s;
        end else begin
            c_fast     = 1'b0;
            c_slow_val = 32'd0 - 32'(c_s - c_p_eff);
        end
    end

    assign mod_start = in_fire && c_fall && !c_fast;
    assign mod_take  = mod_stat.done && rdy_b;

    urpd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (c_slow_val),
        .i_divisor  (c_p_eff),
        .i_take     (mod_take),
        .o_stat     (mod_stat),
        .o_rem      (mod_rem)
    );

    // Stage B: scale by 17 and divide by 100 through the reciprocal.
    always_comb begin
        c_scaled = {1'b0, r_b_int, 4'b0} + urpd_pkg::SCALED_W'(r_b_int);
        c_prod   = urpd_pkg::PROD_W'(c_scaled) * urpd_pkg::PROD_W'(urpd_pkg::RECIP_MUL);
        c_dist_b = c_prod[urpd_pkg::RECIP_SHIFT +: CW];
        c_back   = (r_ptr >= AW'(urpd_pkg::LAG_MOD))
                 ? AW'(r_ptr - AW'(urpd_pkg::LAG_MOD))
                 : AW'(r_ptr + AW'(urpd_pkg::RING_DEPTH - urpd_pkg::LAG_MOD));
        c_ptr_next = (r_ptr == AW'(urpd_pkg::RING_DEPTH - 1)) ? '0 : r_ptr + AW'(1);
        // The measurement leaving stage C writes in this same cycle.
        c_fwd    = mv_co && r_c_done && (r_c_ptr == c_back);
    end

    assign ram_re = mv_bc && r_b_done;
    assign ram_we = mv_co && r_c_done;

    urpd_ram #(
        .WIDTH (CW),
        .DEPTH (urpd_pkg::RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c_ptr),
        .i_wdata (r_c_dist),
        .i_re    (ram_re),
        .i_raddr (c_back),
        .o_rdata (ram_rdata)
    );

    // Stage C: speed against the lagged distance, then the flags.
    always_comb begin
        c_old = r_c_fwd ? r_c_fwd_dist : (r_c_old_vld ? ram_rdata : '0);
        c_diff = (r_c_dist >= c_old) ? r_c_dist - c_old : c_old - r_c_dist;
        c_new_dist  = r_c_done ? r_c_dist : r_last_dist;
        c_new_speed = r_c_done ? c_diff : r_last_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= urpd_pkg::PERIOD_RST;
            r_near      <= urpd_pkg::NEAR_RST;
            r_far       <= urpd_pkg::FAR_RST;
            r_speed_lim <= urpd_pkg::SPEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                urpd_pkg::CFG_PERIOD: r_period    <= i_cfg_data[TW-1:0];
                urpd_pkg::CFG_NEAR:   r_near      <= i_cfg_data[CW-1:0];
                urpd_pkg::CFG_FAR:    r_far       <= i_cfg_data[CW-1:0];
                urpd_pkg::CFG_SPEED:  r_speed_lim <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_trig       <= 1'b0;
            r_echo_last  <= 1'b0;
            r_start      <= '0;
            r_ptr        <= '0;
            r_last_dist  <= '0;
            r_last_speed <= '0;
            r_ring_vld   <= '0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (in_fire) begin
                r_tick      <= n_tick;
                r_trig      <= n_trig;
                r_echo_last <= i_tick.echo_level;
                if (c_rise) begin
                    r_start <= n_tick;
                end
            end
            if (rdy_b) begin
                r_b_valid <= (in_fire && !mod_start) || mod_take;
            end
            if (ram_re) begin
                r_ptr <= c_ptr_next;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (ram_we) begin
                r_ring_vld[r_c_ptr] <= 1'b1;
                r_last_dist         <= r_c_dist;
                r_last_speed        <= c_diff;
            end
            if (rdy_o) begin
                r_o_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_m_trig <= n_trig;
        end
        if (rdy_b) begin
            if (mod_take) begin
                r_b_done <= 1'b1;
                r_b_trig <= r_m_trig;
                r_b_int  <= mod_rem;
            end else begin
                r_b_done <= c_fall;
                r_b_trig <= n_trig;
                r_b_int  <= c_fast_int;
            end
        end
        if (mv_bc) begin
            r_c_done     <= r_b_done;
            r_c_trig     <= r_b_trig;
            r_c_dist     <= c_dist_b;
            r_c_ptr      <= r_ptr;
            r_c_fwd      <= c_fwd;
            r_c_fwd_dist <= r_c_dist;
            r_c_old_vld  <= r_ring_vld[c_back];
        end
        if (mv_co) begin
            r_o_trig     <= r_c_trig;
            r_o_done     <= r_c_done;
            r_o_dist     <= c_new_dist;
            r_o_speed    <= c_new_speed;
            r_o_parked   <= (c_new_dist < r_near) && (c_new_speed < r_speed_lim);
            r_o_unparked <= (c_new_dist > r_far);
        end
    end

    assign o_res.valid         = r_o_valid;
    assign o_res.trigger_level = r_o_trig;
    assign o_res.measure_done  = r_o_done;
    assign o_res.distance_cm   = r_o_dist;
    assign o_res.speed_cm      = r_o_speed;
    assign o_res.parked        = r_o_parked;
    assign o_res.unparked      = r_o_unparked;

`ifndef NO_ASSERTIONS
    // No tick may enter while a measurement waits on the remainder unit.
    a_no_accept_in_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_stat.busy |-> !in_fire)
        else $error("tick transfer accepted while remainder unit busy");

    // A forwarded lagged distance only ever belongs to a measurement.
    a_fwd_is_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_fwd) |-> r_c_done)
        else $error("ring forward on a tick without a measurement");

    // Every ring write leaves its entry marked valid.
    a_ring_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_ring_vld[$past(r_c_ptr)])
        else $error("ring entry not marked valid after write");

    // The remainder handed back is already reduced below the period.
    a_mod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mod_take && !$past(i_cfg_we)) |-> (mod_rem < c_p_eff || $past(i_cfg_we, 2)))
        else $error("remainder not below period");
`endif
endmodule

### bench/ultrasonic_ranger_park_detect_test.sv
// Self-checking testbench for the ultrasonic ranger with park detection.
// Depends on urpd_pkg, urpd_in_if, urpd_out_if and ultrasonic_ranger_park_detect.
// Directed and random echo traffic is predicted per tick and checked field by field.
module ultrasonic_ranger_park_detect_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_PAD      = 8;
    localparam int RANDOM_ITEMS   = 500;

    typedef struct packed {
        logic                      trigger_level;
        logic                      measure_done;
        logic [urpd_pkg::CM_W-1:0] distance_cm;
        logic [urpd_pkg::CM_W-1:0] speed_cm;
        logic                      parked;
        logic                      unparked;
    } t_range_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [urpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [urpd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    urpd_in_if  tick_if ();
    urpd_out_if res_if ();

    ultrasonic_ranger_park_detect i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted ranger state and register copies.
    logic [urpd_pkg::TICK_W-1:0] cfg_period;
    logic [urpd_pkg::CM_W-1:0]   cfg_near;
    logic [urpd_pkg::CM_W-1:0]   cfg_far;
    logic [urpd_pkg::CM_W-1:0]   cfg_speed_limit;
    logic [urpd_pkg::TICK_W-1:0] tick_cnt;
    logic                        trigger_q;
    logic                        echo_q;
    logic [urpd_pkg::TICK_W-1:0] echo_start_q;
    logic [urpd_pkg::CM_W-1:0]   range_ring [urpd_pkg::RING_DEPTH];
    int unsigned                 ring_ptr;
    logic [urpd_pkg::CM_W-1:0]   distance_q;
    logic [urpd_pkg::CM_W-1:0]   speed_q;

    t_range_result pending_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   gap_pct = 0;
    int unsigned   stall_pct = 0;

    task automatic reset_ranger_model();
        cfg_period      = urpd_pkg::PERIOD_RST;
        cfg_near        = urpd_pkg::NEAR_RST;
        cfg_far         = urpd_pkg::FAR_RST;
        cfg_speed_limit = urpd_pkg::SPEED_RST;
        tick_cnt        = '0;
        trigger_q       = 1'b0;
        echo_q          = 1'b0;
        echo_start_q    = '0;
        for (int i = 0; i < urpd_pkg::RING_DEPTH; i++) range_ring[i] = '0;
        ring_ptr        = 0;
        distance_q      = '0;
        speed_q         = '0;
    endtask

    function automatic t_range_result predict_tick(input logic echo);
        t_range_result             res;
        bit [31:0]                 eff_period;
        bit [31:0]                 now_cnt;
        bit [31:0]                 start_cnt;
        bit [31:0]                 span;
        bit [31:0]                 back;
        logic [urpd_pkg::CM_W-1:0] range_cm;
        logic [urpd_pkg::CM_W-1:0] old_cm;
        logic                      done;
        done = 1'b0;
        tick_cnt = tick_cnt + urpd_pkg::TICK_W'(1);
        if (tick_cnt == 1)
            trigger_q = 1'b1;
        else if (tick_cnt == 2)
            trigger_q = 1'b0;
        else if (tick_cnt >= cfg_period)
            tick_cnt = '0;

        if (echo && !echo_q) begin
            echo_start_q = tick_cnt;
        end else if (!echo && echo_q) begin
            eff_period = (cfg_period < urpd_pkg::PERIOD_MIN) ? 32'(urpd_pkg::PERIOD_MIN)
                                                             : 32'(cfg_period);
            now_cnt    = 32'(tick_cnt);
            start_cnt  = 32'(echo_start_q);
            // The wrapped case is plain 32-bit unsigned arithmetic and may underflow.
            span = (now_cnt >= start_cnt) ? now_cnt - start_cnt
                                          : now_cnt + eff_period - start_cnt;
            span = span % eff_period;
            range_cm = urpd_pkg::CM_W'((span * 17) / 100);
            back     = (ring_ptr + urpd_pkg::RING_DEPTH
                        - (urpd_pkg::LAG % urpd_pkg::RING_DEPTH)) % urpd_pkg::RING_DEPTH;
            old_cm   = range_ring[back];
            speed_q  = (range_cm >= old_cm) ? range_cm - old_cm : old_cm - range_cm;
            distance_q = range_cm;
            range_ring[ring_ptr] = range_cm;
            ring_ptr = (ring_ptr + 1) % urpd_pkg::RING_DEPTH;
            done = 1'b1;
        end
        echo_q = echo;

        res.trigger_level = trigger_q;
        res.measure_done  = done;
        res.distance_cm   = distance_q;
        res.speed_cm      = speed_q;
        res.parked        = (distance_q < cfg_near) && (speed_q < cfg_speed_limit);
        res.unparked      = (distance_q > cfg_far);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && tick_if.valid && tick_if.ready)
            pending_results.push_back(predict_tick(tick_if.echo_level));
    end

    task automatic check_field(input string name, input logic [urpd_pkg::CM_W-1:0] want,
                               input logic [urpd_pkg::CM_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_range_result got;
        t_range_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.trigger_level = res_if.trigger_level;
            got.measure_done  = res_if.measure_done;
            got.distance_cm   = res_if.distance_cm;
            got.speed_cm      = res_if.speed_cm;
            got.parked        = res_if.parked;
            got.unparked      = res_if.unparked;
            if (pending_results.size() == 0) begin
                $display("%0t: result with no tick pending, expected none, actual %h",
                         $time, got);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("trigger_level", urpd_pkg::CM_W'(want.trigger_level),
                            urpd_pkg::CM_W'(got.trigger_level));
                check_field("measure_done", urpd_pkg::CM_W'(want.measure_done),
                            urpd_pkg::CM_W'(got.measure_done));
                check_field("distance_cm", want.distance_cm, got.distance_cm);
                check_field("speed_cm", want.speed_cm, got.speed_cm);
                check_field("parked", urpd_pkg::CM_W'(want.parked),
                            urpd_pkg::CM_W'(got.parked));
                check_field("unparked", urpd_pkg::CM_W'(want.unparked),
                            urpd_pkg::CM_W'(got.unparked));
            end
        end
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic echo);
        while ($urandom_range(0, 99) < gap_pct) begin
            tick_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        tick_if.valid      <= 1'b1;
        tick_if.echo_level <= echo;
        do @(posedge i_clk); while (!tick_if.ready);
    endtask

    task automatic send_pulse(input int unsigned high_len, input int unsigned low_len);
        repeat (high_len) send_tick(1'b1);
        repeat (low_len) send_tick(1'b0);
    endtask

    // Stops the tick stream and lets the block finish every outstanding transfer.
    task automatic wait_results_drained();
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input urpd_pkg::t_cfg_idx idx,
                             input logic [urpd_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            urpd_pkg::CFG_PERIOD: cfg_period      = value[urpd_pkg::TICK_W-1:0];
            urpd_pkg::CFG_NEAR:   cfg_near        = value[urpd_pkg::CM_W-1:0];
            urpd_pkg::CFG_FAR:    cfg_far         = value[urpd_pkg::CM_W-1:0];
            urpd_pkg::CFG_SPEED:  cfg_speed_limit = value[urpd_pkg::CM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_pulse(2, 1);
    endtask

    // Periods below the minimum must behave as the minimum.
    task automatic test_small_period();
        for (int p = 0; p <= 3; p++) begin
            wait_results_drained();
            write_reg(urpd_pkg::CFG_PERIOD, urpd_pkg::CFG_DATA_W'(p));
            send_pulse(1, 1);
        end
    endtask

    // Lowering the period below a latched echo start forces the wrapped interval.
    task automatic test_period_lowered();
        wait_results_drained();
        write_reg(urpd_pkg::CFG_PERIOD, 14'd16383);
        send_pulse(0, 8);
        send_tick(1'b1);
        wait_results_drained();
        write_reg(urpd_pkg::CFG_PERIOD, 14'd5);
        send_tick(1'b0);
    endtask

    task automatic test_threshold_extremes();
        wait_results_drained();
        write_reg(urpd_pkg::CFG_PERIOD, 14'd200);
        write_reg(urpd_pkg::CFG_NEAR, 14'd4095);
        write_reg(urpd_pkg::CFG_FAR, 14'd0);
        write_reg(urpd_pkg::CFG_SPEED, 14'd4095);
        send_pulse(1, 1);
        wait_results_drained();
        write_reg(urpd_pkg::CFG_NEAR, 14'd0);
        write_reg(urpd_pkg::CFG_FAR, 14'd4095);
        write_reg(urpd_pkg::CFG_SPEED, 14'd0);
        send_pulse(1, 1);
    endtask

    // A rising edge at count 2 of a three-tick period, followed by a falling edge
    // at count 1 once the period is at its longest, gives the largest distance.
    task automatic test_max_distance();
        wait_results_drained();
        write_reg(urpd_pkg::CFG_PERIOD, 14'd3);
        write_reg(urpd_pkg::CFG_FAR, 14'd2000);
        send_tick(1'b0);
        wait_results_drained();
        while (tick_cnt != urpd_pkg::TICK_W'(1)) begin
            send_tick(1'b0);
            wait_results_drained();
        end
        send_pulse(2, 0);
        wait_results_drained();
        write_reg(urpd_pkg::CFG_PERIOD, 14'd16383);
        send_tick(1'b0);
    endtask

    task automatic load_random_config();
        logic [urpd_pkg::CFG_DATA_W-1:0] value;
        wait_results_drained();
        case ($urandom_range(0, 9))
            0:       value = urpd_pkg::CFG_DATA_W'($urandom_range(0, 2));
            1:       value = urpd_pkg::CFG_DATA_W'($urandom_range(1000, 16383));
            default: value = urpd_pkg::CFG_DATA_W'($urandom_range(3, 80));
        endcase
        write_reg(urpd_pkg::CFG_PERIOD, value);
        for (int r = urpd_pkg::CFG_NEAR; r <= urpd_pkg::CFG_SPEED; r++) begin
            case ($urandom_range(0, 9))
                0:       value = 14'd0;
                1:       value = 14'd4095;
                default: value = urpd_pkg::CFG_DATA_W'($urandom_range(0, 12));
            endcase
            // Bits above the register width must be dropped by the block.
            value[urpd_pkg::CFG_DATA_W-1:urpd_pkg::CM_W] = 2'($urandom_range(0, 3));
            write_reg(urpd_pkg::t_cfg_idx'(r), value);
        end
    endtask

    task automatic run_random_ticks(input int unsigned count);
        int unsigned sent;
        int unsigned high_len;
        int unsigned low_len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                high_len = $urandom_range(1, 24);
                low_len  = $urandom_range(1, 8);
                send_pulse(high_len, low_len);
                sent += high_len + low_len;
            end else begin
                low_len = $urandom_range(1, 6);
                repeat (low_len) send_tick(1'($urandom_range(0, 1)));
                sent += low_len;
            end
        end
    endtask

    task automatic test_random_traffic();
        int unsigned gaps [4]   = '{0, 53, 0, 23};
        int unsigned stalls [4] = '{0, 0, 53, 23};
        for (int m = 0; m < 4; m++) begin
            gap_pct   = gaps[m];
            stall_pct = stalls[m];
            load_random_config();
            run_random_ticks(RANDOM_ITEMS / 8);
            load_random_config();
            run_random_ticks(RANDOM_ITEMS / 8);
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= urpd_pkg::CFG_PERIOD;
        i_cfg_data         <= '0;
        tick_if.valid      <= 1'b0;
        tick_if.echo_level <= 1'b0;
        reset_ranger_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_small_period();
        test_period_lowered();
        test_threshold_extremes();
        test_max_distance();
        test_random_traffic();
        wait_results_drained();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
